/* src/gsps_pkg.sv */
package gsps_pkg;

    localparam int MAX_SCAN_LIMIT = 16;
    localparam int AGE_BITS       = MAX_SCAN_LIMIT + 7;
    localparam int WIN_LEN        = 5;
    localparam int SIG_LEN        = WIN_LEN + 1;
    localparam int SL_W           = $clog2(MAX_SCAN_LIMIT + 1);
    localparam int OUT_DEPTH      = SIG_LEN + 1;
    localparam int QC_W           = $clog2(OUT_DEPTH + 1);
    localparam int EI_W           = $clog2(SIG_LEN);
    localparam int NE_W           = $clog2(SIG_LEN + 1);
    localparam int FILL_W         = $clog2(WIN_LEN + 1);

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;

    localparam logic [CFG_IDX_W-1:0] REG_START_SIG_A = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START_SIG_B = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_START_SIG_C = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_END_SIG_A   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_END_SIG_B   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_REPL_A      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_REPL_B      = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SCAN_LIMIT  = 3'd7;

    localparam logic [23:0] RST_START_SIG_A = 24'h488B12;
    localparam logic [23:0] RST_START_SIG_B = 24'h488D0D;
    localparam logic [23:0] RST_START_SIG_C = 24'h488BD0;
    localparam logic [47:0] RST_END_SIG_A   = 48'h85C00F94C3E8;
    localparam logic [47:0] RST_END_SIG_B   = 48'h85C00F94C188;
    localparam logic [47:0] RST_REPL_A      = 48'h31C00F94C3E8;
    localparam logic [47:0] RST_REPL_B      = 48'h31C00F94C188;
    localparam logic [4:0]  RST_SCAN_LIMIT  = 5'd14;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        replaced;
        logic [15:0] match_count;
        logic        out_last;
    } t_out_item;

endpackage

/* src/gsps_in_if.sv */
interface gsps_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last;

    modport source (output valid, output data_byte, output last, input ready);
    modport sink   (input valid, input data_byte, input last, output ready);
endinterface

/* src/gsps_out_if.sv */
interface gsps_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_byte;
    logic        replaced;
    logic [15:0] match_count;
    logic        out_last;

    modport source (output valid, output out_byte, output replaced, output match_count,
                    output out_last, input ready);
    modport sink   (input valid, input out_byte, input replaced, input match_count,
                    input out_last, output ready);
endinterface

/* src/gsps_cfg_if.sv */
interface gsps_cfg_if import gsps_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* src/gapped_signature_patch_scanner_top.sv */
// Channel  Dir  Payload                                        Transaction when
// i_in     in   data_byte[7:0], last                           valid & ready
// o_out    out  out_byte[7:0], replaced, match_count[15:0],    valid & ready
//               out_last
// i_cfg    in   index[2:0], data[47:0]                         valid & ready (ready tied high)
//
// One input byte per cycle. Scanning, start/end matching and claim selection are
// done in the cycle of the input transaction; results land in a 7-entry output queue.
// A normal byte yields at most one result; a byte flagged last yields up to six.
// i_in.ready is high while the queue holds at most one entry, so a flush stalls
// the input until the queue drains at the output rate.
// Synchronous active-low reset restores register defaults and clears the stream state,
// the queue and the match counter.
module gapped_signature_patch_scanner_top import gsps_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    gsps_in_if.sink      i_in,
    gsps_cfg_if.sink     i_cfg,
    gsps_out_if.source   o_out
);

    // configuration registers
    logic [23:0] r_start_sig_a, r_start_sig_b, r_start_sig_c;
    logic [47:0] r_end_sig_a, r_end_sig_b, r_repl_a, r_repl_b;
    logic [4:0]  r_scan_limit;

    // stream state
    logic [7:0]          r_win [WIN_LEN];
    logic [FILL_W-1:0]   r_fill;
    logic [WIN_LEN-1:0]  r_marks;
    logic [AGE_BITS-1:0] r_pend;
    logic [15:0]         r_count;
    logic [15:0]         r_raw_hist;
    logic [1:0]          r_raw_seen;

    // output queue, head at entry 0
    t_out_item       r_q [OUT_DEPTH];
    logic [QC_W-1:0] r_q_cnt;

    t_out_item       n_q [OUT_DEPTH];
    logic [QC_W-1:0] n_q_cnt;
    logic [AGE_BITS-1:0] n_pend;
    logic [15:0]         n_count;

    logic                l_acc, l_pop, l_full, l_start, l_hit_a, l_hit_b, l_patch, l_found;
    logic [SL_W-1:0]     l_sl;
    logic [23:0]         l_sig;
    logic [47:0]         l_v, l_rep;
    logic [7:0]          l_u  [SIG_LEN];
    logic                l_um [SIG_LEN];
    logic [AGE_BITS-1:0] l_mask, l_cover, l_pend_sh, l_cand, l_oldest;
    logic [NE_W-1:0]     l_n_emit;
    t_out_item           l_e [SIG_LEN];
    logic [QC_W-1:0]     l_base, l_off;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = (r_q_cnt <= QC_W'(OUT_DEPTH - SIG_LEN));
    assign l_acc       = i_in.valid && i_in.ready;

    assign o_out.valid       = (r_q_cnt != '0);
    assign o_out.out_byte    = r_q[0].out_byte;
    assign o_out.replaced    = r_q[0].replaced;
    assign o_out.match_count = r_q[0].match_count;
    assign o_out.out_last    = r_q[0].out_last;
    assign l_pop             = o_out.valid && o_out.ready;

    // scan and patch for the byte on the input channel
    always_comb begin
        l_sl = (int'(r_scan_limit) > MAX_SCAN_LIMIT) ? SL_W'(MAX_SCAN_LIMIT)
                                                     : SL_W'(r_scan_limit);
        l_full = (r_fill == FILL_W'(WIN_LEN));

        // window plus incoming byte; slots past the fill are don't-care
        for (int i = 0; i < WIN_LEN; i++) begin
            l_u[i]  = (FILL_W'(i) < r_fill) ? r_win[i] : i_in.data_byte;
            l_um[i] = (FILL_W'(i) < r_fill) && r_marks[i];
        end
        l_u[SIG_LEN-1]  = i_in.data_byte;
        l_um[SIG_LEN-1] = 1'b0;

        // start detection on raw bytes
        l_sig   = {r_raw_hist, i_in.data_byte};
        l_start = (r_raw_seen == 2'd2) &&
                  (l_sig == r_start_sig_a || l_sig == r_start_sig_b ||
                   l_sig == r_start_sig_c);

        for (int i = 0; i < AGE_BITS; i++) begin
            l_mask[i]  = (i < 7 + int'(l_sl));
            l_cover[i] = (i >= 6) && (i <= 6 + int'(l_sl));
        end
        l_pend_sh = ({r_pend[AGE_BITS-2:0], 1'b0} & l_mask) | AGE_BITS'(l_start);

        l_v = '0;
        for (int i = 0; i < SIG_LEN; i++) begin
            l_v = {l_v[39:0], l_u[i]};
        end
        l_hit_a = l_full && (l_v == r_end_sig_a);
        l_hit_b = l_full && !l_hit_a && (l_v == r_end_sig_b);
        l_rep   = l_hit_a ? r_repl_a : r_repl_b;

        // oldest pending start in reach claims the match
        l_cand  = l_pend_sh & l_cover;
        l_patch = (l_hit_a || l_hit_b) && (l_cand != '0);
        l_found = 1'b0;
        for (int a = AGE_BITS - 1; a >= 0; a--) begin
            l_oldest[a] = l_cand[a] && !l_found;
            l_found     = l_found || l_cand[a];
        end
        n_pend = l_patch ? (l_pend_sh & ~l_oldest) : l_pend_sh;

        if (l_patch) begin
            for (int i = 0; i < SIG_LEN; i++) begin
                l_u[i]  = l_rep[8*(SIG_LEN-1-i) +: 8];
                l_um[i] = 1'b1;
            end
        end
        n_count = (l_patch && r_count != 16'hFFFF) ? r_count + 16'd1 : r_count;

        if (l_full) begin
            l_n_emit = i_in.last ? NE_W'(SIG_LEN) : NE_W'(1);
        end else begin
            l_n_emit = i_in.last ? NE_W'(r_fill) + NE_W'(1) : '0;
        end
        for (int k = 0; k < SIG_LEN; k++) begin
            l_e[k].out_byte    = l_u[k];
            l_e[k].replaced    = l_um[k];
            l_e[k].match_count = n_count;
            l_e[k].out_last    = i_in.last && (NE_W'(k + 1) == l_n_emit);
        end
    end

    // queue: pop from the head, append the new results behind what stays
    always_comb begin
        for (int j = 0; j < OUT_DEPTH - 1; j++) begin
            n_q[j] = l_pop ? r_q[j+1] : r_q[j];
        end
        n_q[OUT_DEPTH-1] = r_q[OUT_DEPTH-1];
        l_base = r_q_cnt - QC_W'(l_pop);
        l_off  = '0;
        if (l_acc) begin
            for (int j = 0; j < OUT_DEPTH; j++) begin
                l_off = QC_W'(j) - l_base;
                if (QC_W'(j) >= l_base && l_off < QC_W'(l_n_emit)) begin
                    n_q[j] = l_e[EI_W'(l_off)];
                end
            end
        end
        n_q_cnt = l_base + (l_acc ? QC_W'(l_n_emit) : '0);
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
        if (l_acc && !i_in.last) begin
            for (int i = 0; i < WIN_LEN; i++) begin
                r_win[i] <= l_full ? l_u[i+1] : l_u[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_sig_a <= RST_START_SIG_A;
            r_start_sig_b <= RST_START_SIG_B;
            r_start_sig_c <= RST_START_SIG_C;
            r_end_sig_a   <= RST_END_SIG_A;
            r_end_sig_b   <= RST_END_SIG_B;
            r_repl_a      <= RST_REPL_A;
            r_repl_b      <= RST_REPL_B;
            r_scan_limit  <= RST_SCAN_LIMIT;
            r_fill        <= '0;
            r_marks       <= '0;
            r_pend        <= '0;
            r_count       <= '0;
            r_raw_hist    <= '0;
            r_raw_seen    <= '0;
            r_q_cnt       <= '0;
        end else begin
            r_q_cnt <= n_q_cnt;
            if (i_cfg.valid) begin
                case (i_cfg.index)
                    REG_START_SIG_A: r_start_sig_a <= i_cfg.data[23:0];
                    REG_START_SIG_B: r_start_sig_b <= i_cfg.data[23:0];
                    REG_START_SIG_C: r_start_sig_c <= i_cfg.data[23:0];
                    REG_END_SIG_A:   r_end_sig_a   <= i_cfg.data;
                    REG_END_SIG_B:   r_end_sig_b   <= i_cfg.data;
                    REG_REPL_A:      r_repl_a      <= i_cfg.data;
                    REG_REPL_B:      r_repl_b      <= i_cfg.data;
                    REG_SCAN_LIMIT:  r_scan_limit  <= i_cfg.data[4:0];
                    default: ;
                endcase
            end
            if (l_acc) begin
                r_count <= n_count;
                if (i_in.last) begin
                    // end of image: next byte starts afresh
                    r_fill     <= '0;
                    r_marks    <= '0;
                    r_pend     <= '0;
                    r_raw_hist <= '0;
                    r_raw_seen <= '0;
                end else begin
                    r_pend     <= n_pend;
                    r_raw_hist <= {r_raw_hist[7:0], i_in.data_byte};
                    if (r_raw_seen != 2'd2) begin
                        r_raw_seen <= r_raw_seen + 2'd1;
                    end
                    if (!l_full) begin
                        r_fill <= r_fill + FILL_W'(1);
                    end
                    for (int i = 0; i < WIN_LEN; i++) begin
                        r_marks[i] <= l_full ? l_um[i+1] : l_um[i];
                    end
                end
            end
        end
    end

endmodule
